// File: src/bmf_pkg.sv
`default_nettype none
package bmf_pkg;

    localparam int MAX_HALF  = 7;

    localparam int HALF_W    = 3;
    localparam int CFG_W     = 11;
    localparam int ROW_W     = 11;
    localparam int SUM_W     = 16;
    localparam int CNT_W     = 8;
    localparam int NUM_W     = 17;
    localparam int DEN_W     = 9;
    localparam int REM_W     = 10;
    localparam int QUO_W     = 8;
    localparam int STEP_W    = 5;
    localparam int NRES_W    = 4;
    localparam int MAX_RES   = 8;
    localparam int POS_W     = 14;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_WINDOW_HALF  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_WAIT,
        ST_LOAD,
        ST_DIV,
        ST_EMIT,
        ST_PIXEL,
        ST_WRITE
    } bmf_state_t;

endpackage
`default_nettype wire

// File: src/bmf_in_if.sv
`default_nettype none
interface bmf_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;

    modport source (output valid, output operation, output blue_in, output green_in,
                    output red_in, input ready);
    modport sink (input valid, input operation, input blue_in, input green_in,
                  input red_in, output ready);
endinterface
`default_nettype wire

// File: src/bmf_out_if.sv
`default_nettype none
interface bmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_last;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output frame_last, input ready);
    modport sink (input valid, input blue_out, input green_out, input red_out,
                  input frame_last, output ready);
endinterface
`default_nettype wire

// File: src/box_mean_filter_clipped_unit.sv
`default_nettype none
// per result: a window walk of (rows x cols) line store reads, then the shared restoring
// divider for the blue, green and red channels in turn, then the output transaction
// throughput: one item at a time; a new item is taken only in idle, once every result
// of the last one (up to 8) is taken; the line store read port and the divider set the pace
// reset: counters cleared, window_half 1, image_width 640, image_height 480;
// line store contents are undefined and never cleared
module box_mean_filter_clipped_unit
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    bmf_in_if.sink                  pixels,
    bmf_out_if.source               results,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    localparam int RING  = 2 * MAX_HALF + 1;
    localparam int RW    = $clog2(RING);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    bmf_state_t state_reg, state_next;

    logic [HALF_W-1:0] window_half_reg;
    logic [CFG_W-1:0]  image_width_reg, image_height_reg;

    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [CW-1:0]     in_col_reg, out_col_reg;
    logic [RW-1:0]     in_ring_reg, out_ring_reg;

    logic              op_reg;
    logic [23:0]       pix_reg;
    logic              phase_reg;
    logic [NRES_W-1:0] nres_reg;

    logic [RW-1:0]     walk_ring_reg;
    logic [HALF_W:0]   walk_rows_reg;
    logic [CW-1:0]     walk_col_reg, col_lo_reg, col_hi_reg;
    logic              pend_reg;
    logic [23:0]       rd_data_reg;
    logic [SUM_W-1:0]  sum_b_reg, sum_g_reg, sum_r_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;

    logic [1:0]        ch_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QUO_W-1:0]  q_b_reg, q_g_reg, q_r_reg;

    logic [23:0]       line_mem [DEPTH];

    // effective configuration
    logic [HALF_W-1:0] half_eff;
    logic [WW-1:0]     width_eff;
    logic [CFG_W-1:0]  height_eff;

    always_comb
    begin
        half_eff = (int'(window_half_reg) > MAX_HALF) ? HALF_W'(MAX_HALF) : window_half_reg;
        if (image_width_reg == '0)
            width_eff = WW'(1);
        else if (int'(image_width_reg) > MAX_WIDTH)
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(image_width_reg);
        height_eff = (image_height_reg == '0) ? CFG_W'(1) : image_height_reg;
    end

    // window bounds and readiness of the next output pixel
    logic [POS_W-1:0] h_p, w_m1, h_m1, orow_p, ocol_p, irow_p, icol_p;
    logic [POS_W-1:0] rmax, cmax, r0_p, c0_p;
    logic [HALF_W-1:0] dh;
    logic [RW:0]       ring0_tmp;
    logic              win_ready, can_emit, frame_last_now;

    always_comb
    begin
        h_p    = POS_W'(half_eff);
        w_m1   = POS_W'(width_eff) - POS_W'(1);
        h_m1   = POS_W'(height_eff) - POS_W'(1);
        orow_p = POS_W'(out_row_reg);
        ocol_p = POS_W'(out_col_reg);
        irow_p = POS_W'(in_row_reg);
        icol_p = POS_W'(in_col_reg);
        rmax   = (orow_p + h_p > h_m1) ? h_m1 : orow_p + h_p;
        cmax   = (ocol_p + h_p > w_m1) ? w_m1 : ocol_p + h_p;
        r0_p   = (orow_p > h_p) ? orow_p - h_p : '0;
        c0_p   = (ocol_p > h_p) ? ocol_p - h_p : '0;
        dh     = HALF_W'(orow_p - r0_p);
        if ({1'b0, out_ring_reg} >= (RW+1)'(dh))
            ring0_tmp = {1'b0, out_ring_reg} - (RW+1)'(dh);
        else
            ring0_tmp = {1'b0, out_ring_reg} + (RW+1)'(RING) - (RW+1)'(dh);
        win_ready = (irow_p > rmax) || ((irow_p == rmax) && (icol_p > cmax));
        can_emit  = (int'(nres_reg) < MAX_RES) && (POS_W'(out_row_reg) < POS_W'(height_eff))
                    && win_ready;
        frame_last_now = (orow_p == h_m1) && (ocol_p == w_m1);
    end

    logic in_take, out_take, walk_end, div_end, px_ok;

    always_comb
    begin
        in_take  = pixels.valid && pixels.ready;
        out_take = results.valid && results.ready;
        walk_end = (walk_col_reg == col_hi_reg) && (walk_rows_reg == '0);
        div_end  = (step_reg == STEP_W'(NUM_W - 1));
        px_ok    = (op_reg == OP_PIXEL) && (POS_W'(in_row_reg) < POS_W'(height_eff));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_take) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (can_emit)
                    state_next = ST_SUM;
                else
                    state_next = phase_reg ? ST_IDLE : ST_PIXEL;
            end
            ST_SUM:   if (walk_end) state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_end)
                    state_next = (ch_reg == 2'd2) ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT:
            begin
                if (out_take)
                begin
                    if (last_reg)
                        state_next = phase_reg ? ST_IDLE : ST_PIXEL;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_PIXEL: state_next = px_ok ? ST_WRITE : ST_IDLE;
            ST_WRITE: state_next = ST_CHECK;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pixels.ready       = (state_reg == ST_IDLE);
        results.valid      = (state_reg == ST_EMIT);
        results.blue_out   = q_b_reg;
        results.green_out  = q_g_reg;
        results.red_out    = q_r_reg;
        results.frame_last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_half_reg  <= HALF_W'(1);
            image_width_reg  <= CFG_W'(640);
            image_height_reg <= CFG_W'(480);
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            in_ring_reg      <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            out_ring_reg     <= '0;
            phase_reg        <= 1'b0;
            nres_reg         <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_WINDOW_HALF || cfg_index == REG_IMAGE_WIDTH
                           || cfg_index == REG_IMAGE_HEIGHT))
            begin
                if (cfg_index == REG_WINDOW_HALF)
                    window_half_reg <= cfg_data[HALF_W-1:0];
                if (cfg_index == REG_IMAGE_WIDTH)
                    image_width_reg <= cfg_data;
                if (cfg_index == REG_IMAGE_HEIGHT)
                    image_height_reg <= cfg_data;
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                in_ring_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_ring_reg <= '0;
            end
            if (in_take)
            begin
                phase_reg <= 1'b0;
                nres_reg  <= '0;
            end
            if (state_reg == ST_WRITE)
            begin
                phase_reg <= 1'b1;
                if (POS_W'(in_col_reg) + POS_W'(1) >= POS_W'(width_eff))
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + ROW_W'(1);
                    in_ring_reg <= (int'(in_ring_reg) == RING - 1) ? '0
                                   : in_ring_reg + RW'(1);
                end
                else
                    in_col_reg <= in_col_reg + CW'(1);
            end
            if (out_take)
            begin
                nres_reg <= nres_reg + NRES_W'(1);
                if (last_reg)
                begin
                    // frame done: next pixel starts a new frame
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_ring_reg  <= '0;
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_ring_reg <= '0;
                end
                else if (POS_W'(out_col_reg) + POS_W'(1) >= POS_W'(width_eff))
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + ROW_W'(1);
                    out_ring_reg <= (int'(out_ring_reg) == RING - 1) ? '0
                                    : out_ring_reg + RW'(1);
                end
                else
                    out_col_reg <= out_col_reg + CW'(1);
            end
        end
    end

    // item latch, window walk, accumulation and division
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= pixels.operation;
            pix_reg <= {pixels.red_in, pixels.green_in, pixels.blue_in};
        end
        pend_reg <= (state_reg == ST_SUM);
        if (state_reg == ST_CHECK)
        begin
            walk_ring_reg <= ring0_tmp[RW-1:0];
            walk_rows_reg <= (HALF_W+1)'(rmax - r0_p);
            walk_col_reg  <= CW'(c0_p);
            col_lo_reg    <= CW'(c0_p);
            col_hi_reg    <= CW'(cmax);
            last_reg      <= frame_last_now;
            sum_b_reg     <= '0;
            sum_g_reg     <= '0;
            sum_r_reg     <= '0;
            cnt_reg       <= '0;
            ch_reg        <= '0;
        end
        if (state_reg == ST_SUM)
        begin
            if (walk_col_reg == col_hi_reg)
            begin
                walk_col_reg  <= col_lo_reg;
                walk_rows_reg <= walk_rows_reg - (HALF_W+1)'(1);
                walk_ring_reg <= (int'(walk_ring_reg) == RING - 1) ? '0
                                 : walk_ring_reg + RW'(1);
            end
            else
                walk_col_reg <= walk_col_reg + CW'(1);
        end
        if (pend_reg)
        begin
            sum_b_reg <= sum_b_reg + SUM_W'(rd_data_reg[7:0]);
            sum_g_reg <= sum_g_reg + SUM_W'(rd_data_reg[15:8]);
            sum_r_reg <= sum_r_reg + SUM_W'(rd_data_reg[23:16]);
            cnt_reg   <= cnt_reg + CNT_W'(1);
        end
        if (state_reg == ST_LOAD)
        begin
            unique case (ch_reg)
                2'd0:    num_reg <= {sum_b_reg, 1'b0} + NUM_W'(cnt_reg);
                2'd1:    num_reg <= {sum_g_reg, 1'b0} + NUM_W'(cnt_reg);
                default: num_reg <= {sum_r_reg, 1'b0} + NUM_W'(cnt_reg);
            endcase
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            // restoring division, one numerator bit per cycle, divisor 2*count
            logic [REM_W-1:0] trial;
            logic [REM_W-1:0] den;
            logic             ge;
            trial = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
            den   = REM_W'({cnt_reg, 1'b0});
            ge    = (trial >= den);
            rem_reg  <= ge ? trial - den : trial;
            quo_reg  <= {quo_reg[QUO_W-2:0], ge};
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            step_reg <= step_reg + STEP_W'(1);
            if (div_end)
            begin
                unique case (ch_reg)
                    2'd0:    q_b_reg <= {quo_reg[QUO_W-2:0], ge};
                    2'd1:    q_g_reg <= {quo_reg[QUO_W-2:0], ge};
                    default: q_r_reg <= {quo_reg[QUO_W-2:0], ge};
                endcase
                ch_reg <= ch_reg + 2'd1;
            end
        end
    end

    // line store: one write port, one registered read port
    logic [AW-1:0] wr_addr, rd_addr;

    always_comb
    begin
        wr_addr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
        rd_addr = AW'(walk_ring_reg) * AW'(MAX_WIDTH) + AW'(walk_col_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            line_mem[wr_addr] <= pix_reg;
        rd_data_reg <= line_mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: tb/sv/box_mean_checker.sv
`default_nettype none
module box_mean_checker
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    bmf_in_if                     pixels,
    bmf_out_if                    results,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output int                    errors,
    output int                    outstanding,
    output int                    frames_done,
    output int                    results_seen
);

    localparam int RING_ROWS = 2 * MAX_HALF + 1;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
    } mean_pixel_t;

    mean_pixel_t means_due[$];

    logic [23:0] line_ring [RING_ROWS][MAX_WIDTH];
    int unsigned half_reg, width_reg, height_reg;
    int unsigned in_row, in_col, out_row, out_col;

    function automatic int unsigned cur_half();
        return (half_reg > MAX_HALF) ? MAX_HALF : half_reg;
    endfunction

    function automatic int unsigned cur_width();
        if (width_reg < 1)
            return 1;
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic int unsigned cur_height();
        return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function automatic int unsigned clip_hi(int unsigned v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic bit window_complete(int unsigned r, int unsigned c);
        int unsigned nr, nc;
        nr = clip_hi(r + cur_half(), cur_height() - 1);
        nc = clip_hi(c + cur_half(), cur_width() - 1);
        return (in_row > nr) || (in_row == nr && in_col > nc);
    endfunction

    function automatic logic [7:0] rounded_mean(int unsigned sum, int unsigned cnt);
        return 8'((2 * sum + cnt) / (2 * cnt));
    endfunction

    // pushes every mean whose window is complete, up to the per-transaction cap or the frame's last mean
    task automatic emit_complete(inout int n);
        int unsigned h, w, ht, r0, r1, c0, c1, sb, sg, sr, cnt;
        logic [23:0] px;
        mean_pixel_t m;
        h = cur_half();
        w = cur_width();
        ht = cur_height();
        while (n < MAX_RES && out_row < ht && window_complete(out_row, out_col))
        begin
            r0 = (out_row > h) ? out_row - h : 0;
            r1 = clip_hi(out_row + h, ht - 1);
            c0 = (out_col > h) ? out_col - h : 0;
            c1 = clip_hi(out_col + h, w - 1);
            sb = 0;
            sg = 0;
            sr = 0;
            cnt = 0;
            for (int unsigned r = r0; r <= r1; r++)
            begin
                for (int unsigned c = c0; c <= c1; c++)
                begin
                    px = line_ring[r % RING_ROWS][c];
                    sb += px[7:0];
                    sg += px[15:8];
                    sr += px[23:16];
                    cnt++;
                end
            end
            m.blue = rounded_mean(sb, cnt);
            m.green = rounded_mean(sg, cnt);
            m.red = rounded_mean(sr, cnt);
            m.last = (out_row == ht - 1) && (out_col == w - 1);
            means_due.push_back(m);
            n++;
            if (m.last)
            begin
                in_row = 0;
                in_col = 0;
                out_row = 0;
                out_col = 0;
                break;
            end
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic predict_item(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int n;
        n = 0;
        emit_complete(n);
        if (op == OP_PIXEL && in_row < cur_height())
        begin
            line_ring[in_row % RING_ROWS][in_col] = {r, g, b};
            in_col++;
            if (in_col >= cur_width())
            begin
                in_col = 0;
                in_row++;
            end
            emit_complete(n);
        end
    endtask

    task automatic compare_result();
        mean_pixel_t got, want;
        got = {results.blue_out, results.green_out, results.red_out, results.frame_last};
        results_seen++;
        if (got.last)
            frames_done++;
        if (means_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result transaction: %h", got);
            return;
        end
        want = means_due.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display({"result %0d: expected b=%0d g=%0d r=%0d last=%0d, ",
                          "got b=%0d g=%0d r=%0d last=%0d"},
                         results_seen, want.blue, want.green, want.red, want.last,
                         got.blue, got.green, got.red, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg = 1;
            width_reg = 640;
            height_reg = 480;
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
            errors = 0;
            frames_done = 0;
            results_seen = 0;
            outstanding = 0;
            means_due.delete();
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_WINDOW_HALF || cfg_index == REG_IMAGE_WIDTH
                           || cfg_index == REG_IMAGE_HEIGHT))
            begin
                case (cfg_index)
                    REG_WINDOW_HALF:  half_reg = cfg_data[HALF_W-1:0];
                    REG_IMAGE_WIDTH:  width_reg = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
                in_row = 0;
                in_col = 0;
                out_row = 0;
                out_col = 0;
                means_due.delete();
            end
            if (pixels.valid && pixels.ready)
                predict_item(pixels.operation, pixels.blue_in, pixels.green_in, pixels.red_in);
            if (results.valid && results.ready)
                compare_result();
            outstanding = means_due.size();
        end
    end

    final
    begin
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_box_mean_filter_clipped_unit.sv
`default_nettype none
module tb_box_mean_filter_clipped_unit;
    import bmf_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 3000;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int errors, outstanding, frames_done, results_seen;
    int items_sent, stall_count;
    int tx_idle_pct, rx_idle_pct;
    bit rx_hold_req;

    bmf_in_if  pixels ();
    bmf_out_if results ();

    box_mean_filter_clipped_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_mean_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .results      (results),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding),
        .frames_done  (frames_done),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                results.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            results.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stall_count <= 0;
        else
        begin
            if ((pixels.valid && pixels.ready) || (results.valid && results.ready) || cfg_we)
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("box_mean_filter_clipped_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(logic op, logic [23:0] px);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pixels.valid = 1'b0;
            @(negedge clk);
        end
        pixels.valid = 1'b1;
        pixels.operation = op;
        {pixels.red_in, pixels.green_in, pixels.blue_in} = px;
        // ready is stable between edges, so it is checked at the falling edge
        while (!pixels.ready)
            @(negedge clk);
        @(negedge clk);
        pixels.valid = 1'b0;
        items_sent++;
    endtask

    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(int half, int width, int height);
        wait_idle();
        write_reg(REG_WINDOW_HALF, CFG_W'(half));
        write_reg(REG_IMAGE_WIDTH, CFG_W'(width));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(height));
    endtask

    // drains until the frame closes (at most 200 drains), pausing each time until all means are back
    task automatic flush_frame(int start_frames);
        int guard;
        guard = 0;
        while (frames_done == start_frames && guard < 200)
        begin
            send_item(OP_DRAIN, 24'($urandom));
            while (outstanding != 0)
                @(negedge clk);
            guard++;
        end
    endtask

    task automatic run_frame(int half, int width, int height, bit noisy);
        int start, npx;
        configure(half, width, height);
        start = frames_done;
        npx = width * height;
        for (int i = 0; i < npx; i++)
        begin
            if (noisy && $urandom_range(7) == 0)
                send_item(OP_DRAIN, 24'($urandom));
            send_item(OP_PIXEL, 24'($urandom));
        end
        // extra pixels once input is complete are dropped while means remain
        if (noisy)
            repeat ($urandom_range(2)) send_item(OP_PIXEL, 24'($urandom));
        flush_frame(start);
    endtask

    task automatic run_partial(int half, int width, int height, int npx);
        configure(half, width, height);
        for (int i = 0; i < npx; i++)
            send_item(OP_PIXEL, 24'($urandom));
        repeat (3) send_item(OP_DRAIN, 24'($urandom));
    endtask

    initial
    begin
        int start, w, h, k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixels.valid = 1'b0;
        pixels.operation = OP_PIXEL;
        pixels.blue_in = '0;
        pixels.green_in = '0;
        pixels.red_in = '0;
        rx_hold_req = 1'b0;
        items_sent = 0;
        tx_idle_pct = 16;
        rx_idle_pct = 87;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // default frame size: a few pixels give no complete window yet
        repeat (3) send_item(OP_PIXEL, 24'($urandom));
        send_item(OP_DRAIN, '0);

        // single pixel frame, all-zero and all-ones pixels
        configure(0, 1, 1);
        start = frames_done;
        send_item(OP_PIXEL, 24'hFFFFFF);
        configure(7, 1, 1);
        send_item(OP_PIXEL, 24'h000000);
        // zero size is treated as one; drain with nothing ready
        configure(3, 0, 0);
        send_item(OP_DRAIN, 24'hFFFFFF);
        send_item(OP_PIXEL, 24'h80FF01);

        // 3x3 with mixed extremes, then an extra pixel that starts a new frame
        configure(1, 3, 3);
        start = frames_done;
        for (int i = 0; i < 9; i++)
            send_item(OP_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
        send_item(OP_PIXEL, 24'h123456);
        flush_frame(start);

        // widest, tallest and oversized settings, partial frames only
        run_partial(7, 1024, 1, 24);
        run_partial(0, 1, 1024, 12);
        run_partial(2, 2047, 1, 12);
        run_partial(1, 1, 2047, 12);

        items_sent = 0;
        k = 0;
        while (items_sent < 250)
        begin
            if (items_sent > 80 && k == 0)
            begin
                tx_idle_pct = 87;
                rx_idle_pct = 16;
                k = 1;
            end
            else if (items_sent > 160 && k == 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                k = 2;
                // long receiver hold-off while a frame streams in
                configure(1, 8, 6);
                rx_hold_req = 1'b1;
                start = frames_done;
                for (int i = 0; i < 48; i++)
                    send_item(OP_PIXEL, 24'($urandom));
                flush_frame(start);
                k = 3;
            end
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
            h = (w > 8) ? $urandom_range(2, 1) : $urandom_range(6, 1);
            case ($urandom_range(5))
                0:       run_partial($urandom_range(7), w, h + 2, $urandom_range(w * h));
                1:       run_frame($urandom_range(7), w, h, 1'b1);
                default: run_frame($urandom_range(7), w, h, 1'b0);
            endcase
        end

        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("run covered %0d frames closed and %0d mean pixels checked,", frames_done,
                 results_seen);
        $display("window halves 0..7, sizes 1..2047, drains, dropped pixels and stalls");
        if (errors == 0)
            $display("box_mean_filter_clipped_unit: match");
        else
            $display("box_mean_filter_clipped_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
src/bmf_pkg.sv
src/bmf_in_if.sv
src/bmf_out_if.sv
src/box_mean_filter_clipped_unit.sv
tb/sv/box_mean_checker.sv
tb/sv/tb_box_mean_filter_clipped_unit.sv
